// ===== sv/ihc_pkg.sv =====
// ----------------------------------------------------------------------------
// IPv4 header check package
// Shared widths, constants, verdict codes and the header field record.
// ----------------------------------------------------------------------------
package ihc_pkg;

    localparam int unsigned HEADER_BYTES = 20;
    localparam int unsigned POS_W        = 5;
    localparam int unsigned SUM_W        = 20;
    localparam int unsigned ADDR_W       = 32;

    localparam logic [POS_W-1:0]  POS_IDLE       = POS_W'(HEADER_BYTES);
    localparam logic [POS_W-1:0]  POS_FIRST      = POS_W'(0);
    localparam logic [POS_W-1:0]  POS_TTL        = POS_W'(8);
    localparam logic [POS_W-1:0]  POS_DEST       = POS_W'(16);
    localparam logic [POS_W-1:0]  POS_LAST       = POS_W'(HEADER_BYTES - 1);
    localparam logic [ADDR_W-1:0] BROADCAST_ADDR = 32'hffff_ffff;
    localparam logic [3:0]        IP_VERSION     = 4'd4;
    localparam logic [3:0]        MIN_IHL        = 4'd5;
    localparam logic [15:0]       SUM_ALL_ONES   = 16'hffff;

    typedef enum logic [2:0] {
        VERDICT_ACCEPT   = 3'd0,
        VERDICT_VERSION  = 3'd1,
        VERDICT_SHORT    = 3'd2,
        VERDICT_TTL      = 3'd3,
        VERDICT_DEST     = 3'd4,
        VERDICT_CHECKSUM = 3'd5
    } verdict_t;

    typedef struct packed {
        logic [7:0]        first_byte;
        logic [7:0]        ttl;
        logic [ADDR_W-1:0] dest;
        logic [SUM_W-1:0]  sum;
    } hdr_fields_t;

endpackage

// ===== sv/ihc_accum.sv =====
// ----------------------------------------------------------------------------
// IPv4 header check accumulator
// Tracks the byte position, captures header fields and keeps the running
// sum of big-endian 16-bit words. Raises a done flag after the last byte.
// ----------------------------------------------------------------------------
module ihc_accum
    import ihc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_accept,
    input  logic [7:0]  data_byte,
    input  logic        start_of_packet,
    input  logic        done_clear,
    output logic        done,
    output hdr_fields_t fields
);

    logic [POS_W-1:0] pos_reg, pos_next, pos_eff;
    logic             done_reg, done_next;
    hdr_fields_t      fields_reg, fields_next, fields_eff;

    always_comb begin
        pos_eff    = pos_reg;
        fields_eff = fields_reg;
        if (start_of_packet) begin
            pos_eff    = POS_FIRST;
            fields_eff = '0;
        end

        pos_next    = pos_reg;
        fields_next = fields_reg;
        done_next   = done_reg && !done_clear;

        if (in_accept) begin
            pos_next    = pos_eff;
            fields_next = fields_eff;
            if (pos_eff < POS_IDLE) begin
                if (pos_eff[0] == 1'b0) begin
                    fields_next.sum = fields_eff.sum + {4'b0, data_byte, 8'b0};
                end else begin
                    fields_next.sum = fields_eff.sum + {12'b0, data_byte};
                end
                if (pos_eff == POS_FIRST) begin
                    fields_next.first_byte = data_byte;
                end else if (pos_eff == POS_TTL) begin
                    fields_next.ttl = data_byte;
                end else if (pos_eff >= POS_DEST) begin
                    fields_next.dest = {fields_eff.dest[ADDR_W-9:0], data_byte};
                end
                pos_next = pos_eff + POS_W'(1);
                if (pos_eff == POS_LAST) begin
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= POS_IDLE;
            done_reg   <= 1'b0;
            fields_reg <= '0;
        end else begin
            pos_reg    <= pos_next;
            done_reg   <= done_next;
            fields_reg <= fields_next;
        end
    end

    assign done   = done_reg;
    assign fields = fields_reg;

endmodule

// ===== sv/ihc_judge.sv =====
// ----------------------------------------------------------------------------
// IPv4 header check judge
// Turns the captured header fields into one verdict, checked in priority
// order, with the end-around carry fold of the header sum.
// ----------------------------------------------------------------------------
module ihc_judge
    import ihc_pkg::*;
(
    input  hdr_fields_t       fields,
    input  logic [ADDR_W-1:0] local_address,
    output verdict_t          verdict
);

    logic [16:0] fold1;
    logic [15:0] fold2;

    assign fold1 = {1'b0, fields.sum[15:0]} + {13'b0, fields.sum[SUM_W-1:16]};
    assign fold2 = fold1[15:0] + {15'b0, fold1[16]};

    always_comb begin
        priority if (fields.first_byte[7:4] != IP_VERSION) begin
            verdict = VERDICT_VERSION;
        end else if (fields.first_byte[3:0] < MIN_IHL) begin
            verdict = VERDICT_SHORT;
        end else if (fields.ttl == 8'd0) begin
            verdict = VERDICT_TTL;
        end else if (fields.dest != local_address && fields.dest != BROADCAST_ADDR) begin
            verdict = VERDICT_DEST;
        end else if (fold2 != SUM_ALL_ONES) begin
            verdict = VERDICT_CHECKSUM;
        end else begin
            verdict = VERDICT_ACCEPT;
        end
    end

endmodule

// ===== sv/ipv4_header_check_top.sv =====
// ----------------------------------------------------------------------------
// IPv4 header check top level
// Judges the first 20 header bytes of each packet and gives one verdict.
//
// Channel   Direction  Payload
// s_        in         tdata[7:0] data_byte, tuser[0] start_of_packet
// m_        out        tdata[2:0] verdict, tdata[7:3] zero
// cfg_      in         cfg_wr_data[31:0] local_address
//
// One byte is accepted in every cycle while s_tready is high. The verdict of a
// header is loaded into the output register after its 20th byte sets the done flag.
// The done flag and the output register form a two-deep hold: input stalls
// only while both hold a verdict and the output is not taken.
// Reset is synchronous on aresetn low and leaves the block idle until a
// start byte.
// ----------------------------------------------------------------------------
module ipv4_header_check_top
    import ihc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,    // [7:0] data_byte
    input  logic              s_tuser,    // [0] start_of_packet
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,    // [2:0] verdict, [7:3] zero
    input  logic              cfg_wr_en,
    input  logic [ADDR_W-1:0] cfg_wr_data
);

    logic              done;
    logic              load;
    logic              in_accept;
    hdr_fields_t       fields;
    verdict_t          verdict;
    logic [ADDR_W-1:0] local_addr_reg;
    logic              m_valid_reg, m_valid_next;
    verdict_t          m_verdict_reg, m_verdict_next;

    assign load      = done && (!m_valid_reg || m_tready);
    assign s_tready  = !done || load;
    assign in_accept = s_tvalid && s_tready;

    ihc_accum u_accum (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_accept       (in_accept),
        .data_byte       (s_tdata),
        .start_of_packet (s_tuser),
        .done_clear      (load),
        .done            (done),
        .fields          (fields)
    );

    ihc_judge u_judge (
        .fields        (fields),
        .local_address (local_addr_reg),
        .verdict       (verdict)
    );

    always_comb begin
        m_valid_next   = m_valid_reg && !m_tready;
        m_verdict_next = m_verdict_reg;
        if (load) begin
            m_valid_next   = 1'b1;
            m_verdict_next = verdict;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_addr_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                local_addr_reg <= cfg_wr_data;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_verdict_reg <= m_verdict_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_verdict_reg};

    a_stall_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (done && m_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while a verdict was blocked");

    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(done))
        else $error("verdict appeared without a finished header");

    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && !in_accept) |=> !done)
        else $error("done flag kept after its verdict was loaded");

    a_verdict_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_verdict_reg <= VERDICT_CHECKSUM))
        else $error("verdict code out of range");

endmodule
